// ===== rtl/adm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package adm_pkg;

  // default coordinate width, signed Q16.8
  localparam int unsigned COORD_BITS_DEF = 24;

  // ray components are brought below 2^RAY_LIMIT_W before squaring
  localparam int unsigned RAY_LIMIT_W = 30;

  // squared cosine ratio, Q0.16 with room for 1.0
  localparam int unsigned RATIO_W = 17;
  localparam logic [RATIO_W-1:0] ONE_Q16 = 17'h10000;

  localparam int unsigned WEIGHT_W = 16;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'h0100;

  localparam int unsigned OUT_W = 24;
  localparam int unsigned FRAC_SHIFT = 8;

  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 32;

  typedef enum logic [1:0] {
    REG_CAMERA_X,
    REG_CAMERA_Y,
    REG_CAMERA_Z,
    REG_WEIGHT
  } adm_reg_e;

  // multiply sequence run by the shared serial multiplier
  typedef enum logic [3:0] {
    OP_DOT_X,
    OP_DOT_Y,
    OP_DOT_Z,
    OP_LA_X,
    OP_LA_Y,
    OP_LA_Z,
    OP_LP_X,
    OP_LP_Y,
    OP_LP_Z,
    OP_NUM,
    OP_DEN,
    OP_WEIGHT
  } adm_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RAY,
    ST_ISSUE,
    ST_WAIT,
    ST_DIV,
    ST_UPDATE,
    ST_FINISH
  } adm_state_e;

  typedef logic [RATIO_W-1:0] ratio_t;

endpackage

`default_nettype wire

// ===== rtl/adm_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none

module adm_mul #(
  parameter int unsigned OP_W = 50
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [OP_W-1:0]   a_i,
  input  logic [OP_W-1:0]   b_i,
  output logic              done_o,
  output logic [2*OP_W-1:0] prod_o
);

  localparam int unsigned CNT_W = $clog2(OP_W + 1);

  logic [OP_W-1:0]  a_q;
  logic [OP_W-1:0]  hi_q;
  logic [OP_W-1:0]  lo_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [OP_W:0]    sum;

  // one multiplier bit per cycle, lsb first; product bits shift into lo_q
  assign sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : {(OP_W+1){1'b0}});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CNT_W'(OP_W);
    end else begin
      done_q <= busy_q && (cnt_q == CNT_W'(1));
      if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q  <= a_i;
      hi_q <= '0;
      lo_q <= b_i;
    end else if (busy_q) begin
      hi_q <= sum[OP_W:1];
      lo_q <= {sum[0], lo_q[OP_W-1:1]};
    end
  end

  assign done_o = done_q;
  assign prod_o = {hi_q, lo_q};

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("multiplier restarted while busy");

  a_busy_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q != '0)
    else $error("multiplier busy with empty bit count");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("multiplier done without a run");

endmodule

`default_nettype wire

// ===== rtl/adm_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module adm_div #(
  parameter int unsigned NUM_W = 100
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [NUM_W-1:0]           num_i,
  input  logic [NUM_W-1:0]           den_i,
  output logic                       done_o,
  output logic [adm_pkg::RATIO_W-1:0] quot_o
);

  import adm_pkg::*;

  localparam int unsigned STEP_W = $clog2(RATIO_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(RATIO_W - 1);

  logic [NUM_W:0]   rem_q;
  logic [NUM_W-1:0] den_q;
  ratio_t           q_q;
  logic [STEP_W-1:0] step_q;
  logic             busy_q;
  logic             done_q;
  logic [NUM_W:0]   trial;
  logic [NUM_W:0]   diff;
  logic             ge;

  // restoring division, one quotient bit per cycle, integer bit first
  always_comb begin
    trial = (step_q == '0) ? rem_q : {rem_q[NUM_W-1:0], 1'b0};
    diff  = trial - {1'b0, den_q};
    ge    = trial >= {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= busy_q && (step_q == LAST_STEP);
      if (busy_q) begin
        if (step_q == LAST_STEP) begin
          busy_q <= 1'b0;
        end else begin
          step_q <= step_q + STEP_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= {1'b0, num_i};
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff : trial;
      q_q   <= {q_q[RATIO_W-2:0], ge};
    end
  end

  // zero denominator yields all ones, clamped to 1.0
  assign quot_o = q_q[RATIO_W-1] ? ONE_Q16 : q_q;
  assign done_o = done_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider restarted while busy");

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> step_q <= LAST_STEP)
    else $error("divider step out of range");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("divider done held longer than one cycle");

endmodule

`default_nettype wire

// ===== rtl/angular_distortion_metric.sv =====
// Angular distortion metric. Each input word is one pair of control points,
// actual and projected, in signed Q16.8; both become rays from the camera
// position held in the registers at 0x0, 0x4 and 0x8, and the block keeps the
// running minimum of the squared cosine between the rays, dot^2 / (|a|^2 |p|^2)
// in Q0.16, a zero-length ray counting as 1.0. The word with last_point set
// closes the set and produces one result word, (1 - minimum) times the Q8.8
// weight at 0xC, as unsigned Q8.16; the next word starts a new set. All
// products go through one shared bit-serial multiplier that retires one
// multiplier bit per cycle over S = 2*min(COORD_BITS,30)+2 bits, eleven
// products per word, followed by a restoring divider that forms the 17-bit
// quotient. A word that closes a set also runs the weighting product and the
// hand-off to the output register. Words are taken one at a time; a waiting
// result sits in its own output register and stalls the block only when a
// new result is ready before the old one is taken.
`timescale 1ns / 1ps
`default_nettype none

module angular_distortion_metric #(
  parameter int unsigned COORD_BITS = adm_pkg::COORD_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [adm_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [adm_pkg::APB_DATA_W-1:0] pwdata,
  output logic [adm_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready,
  // input words
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [COORD_BITS-1:0]   actual_x_i,
  input  logic signed [COORD_BITS-1:0]   actual_y_i,
  input  logic signed [COORD_BITS-1:0]   actual_z_i,
  input  logic signed [COORD_BITS-1:0]   projected_x_i,
  input  logic signed [COORD_BITS-1:0]   projected_y_i,
  input  logic signed [COORD_BITS-1:0]   projected_z_i,
  input  logic                           last_point_i,
  // result words
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [adm_pkg::OUT_W-1:0]      distortion_o
);

  import adm_pkg::*;

  // ray magnitudes are cut to at most RAY_LIMIT_W bits
  localparam int unsigned MAG_W = (COORD_BITS > RAY_LIMIT_W) ? RAY_LIMIT_W : COORD_BITS;
  // shift amount for wide rays, at least one bit wide
  localparam int unsigned SH_W  = $clog2(COORD_BITS - MAG_W + 2);
  // sum of three squares of MAG_W-bit values
  localparam int unsigned SUM_W = 2 * MAG_W + 2;
  localparam int unsigned NUM_W = 2 * SUM_W;

  // ---------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------
  logic signed [COORD_BITS-1:0] cam_q [3];
  logic [WEIGHT_W-1:0]          weight_q;
  logic                         cfg_wr;
  adm_reg_e                     cfg_idx;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign cfg_idx = adm_reg_e'(paddr[APB_ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_q[0] <= '0;
      cam_q[1] <= '0;
      cam_q[2] <= '0;
      weight_q <= WEIGHT_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_CAMERA_X: cam_q[0] <= pwdata[COORD_BITS-1:0];
        REG_CAMERA_Y: cam_q[1] <= pwdata[COORD_BITS-1:0];
        REG_CAMERA_Z: cam_q[2] <= pwdata[COORD_BITS-1:0];
        REG_WEIGHT:   weight_q <= pwdata[WEIGHT_W-1:0];
      endcase
    end
  end

  // camera coordinates read back sign-extended
  always_comb begin
    unique case (cfg_idx)
      REG_CAMERA_X: prdata = APB_DATA_W'(cam_q[0]);
      REG_CAMERA_Y: prdata = APB_DATA_W'(cam_q[1]);
      REG_CAMERA_Z: prdata = APB_DATA_W'(cam_q[2]);
      REG_WEIGHT:   prdata = APB_DATA_W'(weight_q);
    endcase
  end

  // ---------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------
  adm_state_e state_q, state_d;
  adm_op_e    op_q;
  logic       last_q;
  logic       mul_start;
  logic       mul_done;
  logic       div_start;
  logic       div_done;
  logic       out_load;
  logic       out_valid_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_RAY;
      ST_RAY:    state_d = ST_ISSUE;
      ST_ISSUE:  state_d = ST_WAIT;
      ST_WAIT: begin
        if (mul_done) begin
          if (op_q == OP_DEN) begin
            state_d = ST_DIV;
          end else if (op_q == OP_WEIGHT) begin
            state_d = ST_FINISH;
          end else begin
            state_d = ST_ISSUE;
          end
        end
      end
      ST_DIV:    if (div_done) state_d = ST_UPDATE;
      ST_UPDATE: state_d = last_q ? ST_ISSUE : ST_IDLE;
      ST_FINISH: if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = (state_q == ST_IDLE);
    mul_start  = (state_q == ST_ISSUE);
    div_start  = (state_q == ST_WAIT) && mul_done && (op_q == OP_DEN);
    out_load   = (state_q == ST_FINISH) && (!out_valid_q || out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_DOT_X;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_valid_i && in_ready_o) begin
        last_q <= last_point_i;
      end
      if (state_q == ST_RAY) begin
        op_q <= OP_DOT_X;
      end else if (state_q == ST_WAIT && mul_done && op_q != OP_DEN &&
                   op_q != OP_WEIGHT) begin
        op_q <= adm_op_e'(op_q + 4'd1);
      end else if (state_q == ST_UPDATE) begin
        op_q <= OP_WEIGHT;
      end
    end
  end

  // ---------------------------------------------------------------------
  // rays: differences taken at acceptance, magnitude and reduction next
  // ---------------------------------------------------------------------
  logic signed [COORD_BITS-1:0] pt_in   [6];
  logic [COORD_BITS:0]          diff_q  [6];
  logic [COORD_BITS:0]          ray_abs [6];
  logic                         ray_neg [6];
  logic [COORD_BITS-1:0]        ray_or  [2];
  logic [SH_W-1:0]              ray_sh  [2];
  logic [MAG_W-1:0]             ray_mag [6];
  logic [MAG_W-1:0]             mag_q   [6];
  logic                         neg_q   [6];

  // slots 0..2 actual point, 3..5 projected point
  assign pt_in[0] = actual_x_i;
  assign pt_in[1] = actual_y_i;
  assign pt_in[2] = actual_z_i;
  assign pt_in[3] = projected_x_i;
  assign pt_in[4] = projected_y_i;
  assign pt_in[5] = projected_z_i;

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      for (int g = 0; g < 2; g++) begin
        for (int c = 0; c < 3; c++) begin
          diff_q[3*g+c] <= {pt_in[3*g+c][COORD_BITS-1], pt_in[3*g+c]} -
                           {cam_q[c][COORD_BITS-1], cam_q[c]};
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      ray_neg[i] = diff_q[i][COORD_BITS];
      ray_abs[i] = ray_neg[i] ? (~diff_q[i] + {{COORD_BITS{1'b0}}, 1'b1}) : diff_q[i];
    end
    for (int g = 0; g < 2; g++) begin
      ray_or[g] = ray_abs[3*g][COORD_BITS-1:0] | ray_abs[3*g+1][COORD_BITS-1:0] |
                  ray_abs[3*g+2][COORD_BITS-1:0];
      // smallest shift that brings every component of the ray below the limit
      ray_sh[g] = '0;
      for (int b = RAY_LIMIT_W; b < COORD_BITS; b++) begin
        if (ray_or[g][b]) ray_sh[g] = SH_W'(b - RAY_LIMIT_W + 1);
      end
      for (int c = 0; c < 3; c++) begin
        ray_mag[3*g+c] = MAG_W'(ray_abs[3*g+c][COORD_BITS-1:0] >> ray_sh[g]);
      end
    end
  end

  // ---------------------------------------------------------------------
  // products and sums
  // ---------------------------------------------------------------------
  logic signed [SUM_W:0] dot_q;
  logic [SUM_W-1:0]      la_q;
  logic [SUM_W-1:0]      lp_q;
  logic [SUM_W-1:0]      dmag;
  logic [NUM_W-1:0]      num_q;
  logic [SUM_W-1:0]      mul_a;
  logic [SUM_W-1:0]      mul_b;
  logic [NUM_W-1:0]      mul_prod;
  logic [SUM_W-1:0]      prod_lo;
  logic                  dot_sub;
  ratio_t                min_q;
  ratio_t                min_new;
  ratio_t                quot;
  ratio_t                err;
  logic                  have_q;

  assign dmag    = dot_q[SUM_W] ? SUM_W'(-dot_q) : dot_q[SUM_W-1:0];
  assign prod_lo = mul_prod[SUM_W-1:0];
  assign err     = ONE_Q16 - min_q;

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    dot_sub = 1'b0;
    unique case (op_q)
      OP_DOT_X: begin
        mul_a   = SUM_W'(mag_q[0]);
        mul_b   = SUM_W'(mag_q[3]);
        dot_sub = neg_q[0] ^ neg_q[3];
      end
      OP_DOT_Y: begin
        mul_a   = SUM_W'(mag_q[1]);
        mul_b   = SUM_W'(mag_q[4]);
        dot_sub = neg_q[1] ^ neg_q[4];
      end
      OP_DOT_Z: begin
        mul_a   = SUM_W'(mag_q[2]);
        mul_b   = SUM_W'(mag_q[5]);
        dot_sub = neg_q[2] ^ neg_q[5];
      end
      OP_LA_X: begin
        mul_a = SUM_W'(mag_q[0]);
        mul_b = SUM_W'(mag_q[0]);
      end
      OP_LA_Y: begin
        mul_a = SUM_W'(mag_q[1]);
        mul_b = SUM_W'(mag_q[1]);
      end
      OP_LA_Z: begin
        mul_a = SUM_W'(mag_q[2]);
        mul_b = SUM_W'(mag_q[2]);
      end
      OP_LP_X: begin
        mul_a = SUM_W'(mag_q[3]);
        mul_b = SUM_W'(mag_q[3]);
      end
      OP_LP_Y: begin
        mul_a = SUM_W'(mag_q[4]);
        mul_b = SUM_W'(mag_q[4]);
      end
      OP_LP_Z: begin
        mul_a = SUM_W'(mag_q[5]);
        mul_b = SUM_W'(mag_q[5]);
      end
      OP_NUM: begin
        mul_a = dmag;
        mul_b = dmag;
      end
      OP_DEN: begin
        mul_a = la_q;
        mul_b = lp_q;
      end
      OP_WEIGHT: begin
        mul_a = SUM_W'(err);
        mul_b = SUM_W'(weight_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_RAY) begin
      mag_q <= ray_mag;
      neg_q <= ray_neg;
      dot_q <= '0;
      la_q  <= '0;
      lp_q  <= '0;
    end else if (state_q == ST_WAIT && mul_done) begin
      unique case (op_q)
        OP_DOT_X, OP_DOT_Y, OP_DOT_Z: begin
          dot_q <= dot_sub ? dot_q - $signed({1'b0, prod_lo})
                           : dot_q + $signed({1'b0, prod_lo});
        end
        OP_LA_X, OP_LA_Y, OP_LA_Z: la_q <= la_q + prod_lo;
        OP_LP_X, OP_LP_Y, OP_LP_Z: lp_q <= lp_q + prod_lo;
        OP_NUM:  num_q <= mul_prod;
        default: ;
      endcase
    end
  end

  adm_mul #(
    .OP_W (SUM_W)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  // den comes straight from the multiplier as it finishes la * lp
  adm_div #(
    .NUM_W (NUM_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_q),
    .den_i   (mul_prod),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  // ---------------------------------------------------------------------
  // running minimum and result
  // ---------------------------------------------------------------------
  assign min_new = (!have_q || quot < min_q) ? quot : min_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q  <= ONE_Q16;
      have_q <= 1'b0;
    end else if (state_q == ST_UPDATE) begin
      min_q  <= min_new;
      have_q <= 1'b1;
    end else if (out_load) begin
      // set closed, start over
      min_q  <= ONE_Q16;
      have_q <= 1'b0;
    end
  end

  logic [OUT_W-1:0] out_data_d;
  logic [OUT_W-1:0] out_data_q;

  // weighted error is Q8.24 before dropping eight fraction bits
  assign out_data_d = (|mul_prod[NUM_W-1:FRAC_SHIFT+OUT_W]) ? {OUT_W{1'b1}}
                    : mul_prod[FRAC_SHIFT+OUT_W-1:FRAC_SHIFT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign distortion_o = out_data_q;

  // ---------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------
  a_min_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    min_q <= ONE_Q16)
    else $error("running minimum above one");

  a_finish_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FINISH |-> last_q)
    else $error("result produced for a word that does not close the set");

  a_mul_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> state_q == ST_WAIT)
    else $error("multiplier finished outside the wait state");

  a_div_done_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("divider finished outside the divide state");

endmodule

`default_nettype wire
